/* src/assert_macros.svh */
// Assertion macros used by hrsp_checker.
// Expects aclk and aresetn in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HRSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define HRSP_ASSERT_NEXT(label, ante, cons, msg) \
    `HRSP_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* src/hrsp_pkg.sv */
// Package for the HTTP response stream parser: item types, control state,
// codes and the header name key tables. No dependencies.
`default_nettype none

package hrsp_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    // result events
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_STATUS   = 3'd1;
    localparam logic [2:0] EV_LINE     = 3'd2;
    localparam logic [2:0] EV_BODY     = 3'd3;
    localparam logic [2:0] EV_COMPLETE = 3'd4;
    localparam logic [2:0] EV_ERROR    = 3'd5;
    localparam logic [2:0] EV_IDLE     = 3'd6;

    // byte roles
    localparam logic [2:0] ROLE_SYNTAX  = 3'd0;
    localparam logic [2:0] ROLE_NAME    = 3'd1;
    localparam logic [2:0] ROLE_VALUE   = 3'd2;
    localparam logic [2:0] ROLE_PENDING = 3'd3;
    localparam logic [2:0] ROLE_BODY    = 3'd4;

    // phases
    localparam logic [2:0] PH_STATUS  = 3'd0;
    localparam logic [2:0] PH_HEADERS = 3'd1;
    localparam logic [2:0] PH_BODY    = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    // status line substates
    localparam logic [3:0] SS_H       = 4'd0;
    localparam logic [3:0] SS_T1      = 4'd1;
    localparam logic [3:0] SS_T2      = 4'd2;
    localparam logic [3:0] SS_P       = 4'd3;
    localparam logic [3:0] SS_SLASH   = 4'd4;
    localparam logic [3:0] SS_MAJOR   = 4'd5;
    localparam logic [3:0] SS_MAJ_DIG = 4'd6;
    localparam logic [3:0] SS_MINOR   = 4'd7;
    localparam logic [3:0] SS_MIN_DIG = 4'd8;
    localparam logic [3:0] SS_CODE    = 4'd9;
    localparam logic [3:0] SS_AFTER   = 4'd10;
    localparam logic [3:0] SS_REASON  = 4'd11;
    localparam logic [3:0] SS_CR      = 4'd12;
    localparam logic [3:0] SS_DONE    = 4'd13;

    // header substates
    localparam logic [2:0] HS_START      = 3'd0;
    localparam logic [2:0] HS_NAME       = 3'd1;
    localparam logic [2:0] HS_PRE_VALUE  = 3'd2;
    localparam logic [2:0] HS_VALUE      = 3'd3;
    localparam logic [2:0] HS_POST_VALUE = 3'd4;
    localparam logic [2:0] HS_SKIP       = 3'd5;
    localparam logic [2:0] HS_LINE_END   = 3'd6;
    localparam logic [2:0] HS_HDR_END    = 3'd7;

    // value flags
    localparam logic [2:0] VF_NONEMPTY = 3'b001;
    localparam logic [2:0] VF_DIRTY    = 3'b010;
    localparam logic [2:0] VF_PENDING  = 3'b100;

    // match flags
    localparam logic [1:0] MF_HTTP = 2'b01;
    localparam logic [1:0] MF_CLEN = 2'b10;

    localparam logic [3:0] HTTP_LEN  = 4'd4;
    localparam logic [3:0] CLEN_LEN  = 4'd14;
    localparam logic [3:0] NAME_SAT  = 4'd15;
    localparam logic [1:0] CODE_DIGS = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CASE  = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  byte_role;
        logic [7:0]  out_char;
        logic [9:0]  resp_status;
        logic [31:0] body_remaining;
    } out_item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] ss;
        logic [2:0] hs;
        logic [9:0] status_value;
        logic [1:0] digit_cnt;
        logic [3:0] name_pos;
        logic [1:0] name_flags;
        logic [2:0] vflags;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{
        phase:        PH_STATUS,
        ss:           SS_H,
        hs:           HS_START,
        status_value: 10'd0,
        digit_cnt:    2'd0,
        name_pos:     4'd0,
        name_flags:   MF_HTTP | MF_CLEN,
        vflags:       3'd0
    };

    function automatic logic [7:0] http_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = "H";
            2'd1:    c = "T";
            2'd2:    c = "T";
            default: c = "P";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/hrsp_step.sv */
// Next-state and result logic for one byte of the response parser.
// Depends on hrsp_pkg.
`default_nettype none

module hrsp_step #(
    parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
    input  hrsp_pkg::in_item_t   in_item,
    input  hrsp_pkg::ctl_t       ctl_q,
    input  logic [LENGTH_BITS-1:0] acc_q,
    input  logic [LENGTH_BITS-1:0] blen_q,
    output hrsp_pkg::ctl_t       ctl_d,
    output logic [LENGTH_BITS-1:0] acc_d,
    output logic [LENGTH_BITS-1:0] blen_d,
    output hrsp_pkg::out_item_t  out_item
);

    hrsp_pkg::ctl_t         cur;
    hrsp_pkg::ctl_t         nxt;
    logic [LENGTH_BITS-1:0] acc;
    logic [LENGTH_BITS-1:0] blen;
    logic [LENGTH_BITS-1:0] acc_n;
    logic [LENGTH_BITS-1:0] blen_n;
    logic [LENGTH_BITS-1:0] bdec;
    logic [LENGTH_BITS+3:0] acc_w;
    logic [LENGTH_BITS+3:0] prod;
    logic [63:0]            blen_wide;
    logic [7:0]             b;
    logic                   dig;
    logic [2:0]             ev;
    logic [2:0]             role;
    logic [7:0]             oc;
    logic [1:0]             nm_flags;
    logic [3:0]             nm_pos;
    logic [7:0]             nm_char;
    logic [2:0]             vc_flags;
    logic [LENGTH_BITS-1:0] vc_acc;
    logic [9:0]             sv_next;
    logic [1:0]             cnt_next;
    logic                   ld_hit;
    logic                   ld_fail;
    logic                   do_name;
    logic                   do_value;
    logic                   do_line;
    logic                   do_hdrs;

    always_comb begin
        cur  = in_item.first ? hrsp_pkg::CTL_RESET : ctl_q;
        acc  = in_item.first ? '0 : acc_q;
        blen = in_item.first ? '0 : blen_q;
        b    = in_item.in_byte;
        dig  = b inside {["0":"9"]};

        // name byte
        nm_flags = cur.name_flags;
        if (cur.name_pos < hrsp_pkg::HTTP_LEN) begin
            if (b != hrsp_pkg::http_char(cur.name_pos[1:0])) begin
                nm_flags = nm_flags & ~hrsp_pkg::MF_HTTP;
            end
        end else begin
            nm_flags = nm_flags & ~hrsp_pkg::MF_HTTP;
        end
        if (cur.name_pos < hrsp_pkg::CLEN_LEN) begin
            if (b != hrsp_pkg::clen_char(cur.name_pos)) begin
                nm_flags = nm_flags & ~hrsp_pkg::MF_CLEN;
            end
        end else begin
            nm_flags = nm_flags & ~hrsp_pkg::MF_CLEN;
        end
        nm_pos = (cur.name_pos != hrsp_pkg::NAME_SAT) ? cur.name_pos + 4'd1 : cur.name_pos;
        if (b inside {["A":"Z"]}) begin
            nm_char = b | hrsp_pkg::CH_CASE;
        end else if (b == "-") begin
            nm_char = "_";
        end else begin
            nm_char = b;
        end

        // value byte
        acc_w    = {4'b0000, acc};
        prod     = (acc_w << 3) + (acc_w << 1) + {{LENGTH_BITS{1'b0}}, b[3:0]};
        vc_flags = cur.vflags;
        vc_acc   = acc;
        if ((vc_flags & hrsp_pkg::VF_PENDING) != 3'd0) begin
            vc_flags = (vc_flags | hrsp_pkg::VF_DIRTY) & ~hrsp_pkg::VF_PENDING;
        end
        vc_flags = vc_flags | hrsp_pkg::VF_NONEMPTY;
        if (dig && (prod[LENGTH_BITS+3:LENGTH_BITS] == 4'd0)) begin
            vc_acc = prod[LENGTH_BITS-1:0];
        end else begin
            vc_flags = vc_flags | hrsp_pkg::VF_DIRTY;
        end

        // line end
        ld_hit  = ((cur.name_flags & hrsp_pkg::MF_CLEN) != 2'd0)
                  && (cur.name_pos == hrsp_pkg::CLEN_LEN) && (blen == '0);
        ld_fail = ld_hit && (((cur.vflags & hrsp_pkg::VF_NONEMPTY) == 3'd0)
                  || ((cur.vflags & hrsp_pkg::VF_DIRTY) != 3'd0));

        sv_next  = (cur.status_value << 3) + (cur.status_value << 1) + {6'd0, b[3:0]};
        cnt_next = cur.digit_cnt + 2'd1;
        bdec     = (blen != '0) ? blen - LENGTH_BITS'(1) : blen;

        nxt      = cur;
        acc_n    = acc;
        blen_n   = blen;
        ev       = hrsp_pkg::EV_NONE;
        role     = hrsp_pkg::ROLE_SYNTAX;
        oc       = b;
        do_name  = 1'b0;
        do_value = 1'b0;
        do_line  = 1'b0;
        do_hdrs  = 1'b0;

        case (cur.phase)
            hrsp_pkg::PH_STATUS: begin
                case (cur.ss)
                    hrsp_pkg::SS_H:
                        if (b == "H") nxt.ss = hrsp_pkg::SS_T1;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_T1:
                        if (b == "T") nxt.ss = hrsp_pkg::SS_T2;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_T2:
                        if (b == "T") nxt.ss = hrsp_pkg::SS_P;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_P:
                        if (b == "P") nxt.ss = hrsp_pkg::SS_SLASH;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_SLASH:
                        if (b == "/") nxt.ss = hrsp_pkg::SS_MAJOR;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_MAJOR:
                        if (b inside {["1":"9"]}) nxt.ss = hrsp_pkg::SS_MAJ_DIG;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_MAJ_DIG:
                        if (b == ".") nxt.ss = hrsp_pkg::SS_MINOR;
                        else if (!dig) nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_MINOR:
                        if (dig) nxt.ss = hrsp_pkg::SS_MIN_DIG;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_MIN_DIG:
                        if (b == hrsp_pkg::CH_SP) nxt.ss = hrsp_pkg::SS_CODE;
                        else if (!dig) nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_CODE: begin
                        if (b == hrsp_pkg::CH_SP) begin
                            nxt.ss = cur.ss;
                        end else if (!dig) begin
                            nxt.phase = hrsp_pkg::PH_ERROR;
                        end else begin
                            nxt.status_value = sv_next;
                            nxt.digit_cnt    = cnt_next;
                            if (cnt_next == hrsp_pkg::CODE_DIGS) nxt.ss = hrsp_pkg::SS_AFTER;
                        end
                    end
                    hrsp_pkg::SS_AFTER:
                        if (b == hrsp_pkg::CH_SP || b == ".") nxt.ss = hrsp_pkg::SS_REASON;
                        else if (b == hrsp_pkg::CH_CR) nxt.ss = hrsp_pkg::SS_CR;
                        else if (b == hrsp_pkg::CH_LF) nxt.ss = hrsp_pkg::SS_DONE;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    hrsp_pkg::SS_REASON:
                        if (b == hrsp_pkg::CH_CR) nxt.ss = hrsp_pkg::SS_CR;
                        else if (b == hrsp_pkg::CH_LF) nxt.ss = hrsp_pkg::SS_DONE;
                    hrsp_pkg::SS_CR:
                        if (b == hrsp_pkg::CH_LF) nxt.ss = hrsp_pkg::SS_DONE;
                        else nxt.phase = hrsp_pkg::PH_ERROR;
                    default:
                        nxt.phase = hrsp_pkg::PH_ERROR;
                endcase
                if (nxt.phase == hrsp_pkg::PH_ERROR) begin
                    ev = hrsp_pkg::EV_ERROR;
                end else if (nxt.ss == hrsp_pkg::SS_DONE) begin
                    nxt.ss         = hrsp_pkg::SS_H;
                    nxt.phase      = hrsp_pkg::PH_HEADERS;
                    nxt.hs         = hrsp_pkg::HS_START;
                    nxt.name_pos   = 4'd0;
                    nxt.name_flags = hrsp_pkg::MF_HTTP | hrsp_pkg::MF_CLEN;
                    nxt.vflags     = 3'd0;
                    acc_n          = '0;
                    ev             = hrsp_pkg::EV_STATUS;
                end
            end
            hrsp_pkg::PH_HEADERS: begin
                case (cur.hs)
                    hrsp_pkg::HS_START:
                        if (b == hrsp_pkg::CH_CR) begin
                            nxt.hs = hrsp_pkg::HS_HDR_END;
                        end else if (b == hrsp_pkg::CH_LF) begin
                            do_hdrs = 1'b1;
                        end else begin
                            nxt.hs  = hrsp_pkg::HS_NAME;
                            do_name = 1'b1;
                        end
                    hrsp_pkg::HS_NAME:
                        if (b == ":") begin
                            nxt.hs = hrsp_pkg::HS_PRE_VALUE;
                        end else if (b == hrsp_pkg::CH_CR) begin
                            nxt.hs = hrsp_pkg::HS_LINE_END;
                        end else if (b == hrsp_pkg::CH_LF) begin
                            do_line = 1'b1;
                        end else if (b == "/" && cur.name_pos == hrsp_pkg::HTTP_LEN
                                     && (cur.name_flags & hrsp_pkg::MF_HTTP) != 2'd0) begin
                            nxt.hs = hrsp_pkg::HS_SKIP;
                        end else begin
                            do_name = 1'b1;
                        end
                    hrsp_pkg::HS_PRE_VALUE:
                        if (b == hrsp_pkg::CH_SP) begin
                            nxt.hs = cur.hs;
                        end else if (b == hrsp_pkg::CH_CR) begin
                            nxt.hs = hrsp_pkg::HS_LINE_END;
                        end else if (b == hrsp_pkg::CH_LF) begin
                            do_line = 1'b1;
                        end else begin
                            nxt.hs   = hrsp_pkg::HS_VALUE;
                            do_value = 1'b1;
                        end
                    hrsp_pkg::HS_VALUE, hrsp_pkg::HS_POST_VALUE:
                        if (b == hrsp_pkg::CH_SP) begin
                            nxt.hs     = hrsp_pkg::HS_POST_VALUE;
                            nxt.vflags = cur.vflags | hrsp_pkg::VF_PENDING;
                            role       = hrsp_pkg::ROLE_PENDING;
                        end else if (b == hrsp_pkg::CH_CR) begin
                            nxt.hs     = hrsp_pkg::HS_LINE_END;
                            nxt.vflags = cur.vflags & ~hrsp_pkg::VF_PENDING;
                        end else if (b == hrsp_pkg::CH_LF) begin
                            nxt.vflags = cur.vflags & ~hrsp_pkg::VF_PENDING;
                            do_line    = 1'b1;
                        end else begin
                            nxt.hs   = hrsp_pkg::HS_VALUE;
                            do_value = 1'b1;
                        end
                    hrsp_pkg::HS_SKIP:
                        if (b == hrsp_pkg::CH_LF) begin
                            nxt.hs         = hrsp_pkg::HS_START;
                            nxt.name_pos   = 4'd0;
                            nxt.name_flags = hrsp_pkg::MF_HTTP | hrsp_pkg::MF_CLEN;
                            nxt.vflags     = 3'd0;
                            acc_n          = '0;
                        end
                    hrsp_pkg::HS_LINE_END:
                        if (b == hrsp_pkg::CH_LF) begin
                            do_line = 1'b1;
                        end else if (b != hrsp_pkg::CH_CR) begin
                            nxt.phase = hrsp_pkg::PH_ERROR;
                            ev        = hrsp_pkg::EV_ERROR;
                        end
                    default:
                        if (b == hrsp_pkg::CH_LF) begin
                            do_hdrs = 1'b1;
                        end else begin
                            nxt.phase = hrsp_pkg::PH_ERROR;
                            ev        = hrsp_pkg::EV_ERROR;
                        end
                endcase
                if (do_name) begin
                    nxt.name_flags = nm_flags;
                    nxt.name_pos   = nm_pos;
                    role           = hrsp_pkg::ROLE_NAME;
                    oc             = nm_char;
                end
                if (do_value) begin
                    nxt.vflags = vc_flags;
                    acc_n      = vc_acc;
                    role       = hrsp_pkg::ROLE_VALUE;
                end
                if (do_line) begin
                    if (ld_fail) begin
                        nxt.phase = hrsp_pkg::PH_ERROR;
                        ev        = hrsp_pkg::EV_ERROR;
                    end else begin
                        if (ld_hit) blen_n = acc;
                        ev             = hrsp_pkg::EV_LINE;
                        nxt.hs         = hrsp_pkg::HS_START;
                        nxt.name_pos   = 4'd0;
                        nxt.name_flags = hrsp_pkg::MF_HTTP | hrsp_pkg::MF_CLEN;
                        nxt.vflags     = 3'd0;
                        acc_n          = '0;
                    end
                end
                if (do_hdrs) begin
                    if (blen == '0) begin
                        nxt.phase = hrsp_pkg::PH_DONE;
                        ev        = hrsp_pkg::EV_COMPLETE;
                    end else begin
                        nxt.phase = hrsp_pkg::PH_BODY;
                        ev        = hrsp_pkg::EV_BODY;
                    end
                end
                if (nxt.phase == hrsp_pkg::PH_ERROR) role = hrsp_pkg::ROLE_SYNTAX;
            end
            hrsp_pkg::PH_BODY: begin
                role   = hrsp_pkg::ROLE_BODY;
                blen_n = bdec;
                if (bdec == '0) begin
                    nxt.phase = hrsp_pkg::PH_DONE;
                    ev        = hrsp_pkg::EV_COMPLETE;
                end
            end
            default: begin
                ev = hrsp_pkg::EV_IDLE;
            end
        endcase

        blen_wide = 64'(blen_n);
    end

    assign ctl_d  = nxt;
    assign acc_d  = acc_n;
    assign blen_d = blen_n;

    assign out_item.event_res      = ev;
    assign out_item.byte_role      = role;
    assign out_item.out_char       = oc;
    assign out_item.resp_status    = nxt.status_value;
    assign out_item.body_remaining = blen_wide[31:0];

endmodule

`default_nettype wire

/* src/http_response_stream_parser.sv */
// Top level of the HTTP/1.x response stream parser: input register, parser
// state registers and result register around hrsp_step. Depends on hrsp_pkg.
`default_nettype none

// Takes one response byte per item and returns exactly one result item per
// byte, at one item per clock sustained while the output is not stalled. A
// byte is held in the input register, and its result is written from there
// into the result register once that register is free or being taken. The
// rate is set by the update of the parser state registers, which every byte
// reads and writes. s_ready stays high while the result register is free
// or being taken; a stalled result keeps one byte waiting in the input
// register. Setting first on a byte clears the parser before that byte is
// parsed. LENGTH_BITS sizes the body length counter; body_remaining shows
// its low 32 bits.
module http_response_stream_parser #(
    parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrsp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output hrsp_pkg::out_item_t m_item
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    hrsp_pkg::in_item_t     in_item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    hrsp_pkg::out_item_t    out_item_reg;
    hrsp_pkg::out_item_t    out_item_next;
    hrsp_pkg::ctl_t         ctl_reg;
    hrsp_pkg::ctl_t         ctl_next;
    logic [LENGTH_BITS-1:0] acc_reg;
    logic [LENGTH_BITS-1:0] acc_next;
    logic [LENGTH_BITS-1:0] blen_reg;
    logic [LENGTH_BITS-1:0] blen_next;
    logic                   advance;
    logic                   s_fire;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    hrsp_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .in_item (in_item_reg),
        .ctl_q   (ctl_reg),
        .acc_q   (acc_reg),
        .blen_q  (blen_reg),
        .ctl_d   (ctl_next),
        .acc_d   (acc_next),
        .blen_d  (blen_next),
        .out_item(out_item_next)
    );

    always_comb begin
        in_valid_next = s_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctl_reg       <= hrsp_pkg::CTL_RESET;
            acc_reg       <= '0;
            blen_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                ctl_reg  <= ctl_next;
                acc_reg  <= acc_next;
                blen_reg <= blen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

`default_nettype wire

/* src/hrsp_checker.sv */
// Port-level checks for http_response_stream_parser, bound to the top level.
// Depends on hrsp_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hrsp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input hrsp_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input hrsp_pkg::out_item_t m_item
);

    `HRSP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result item changed while stalled")

    `HRSP_ASSERT(a_codes, m_valid |-> (m_item.event_res <= hrsp_pkg::EV_IDLE && m_item.byte_role <= hrsp_pkg::ROLE_BODY), "event or role code out of range")

    `HRSP_ASSERT(a_status_range, m_valid |-> (m_item.resp_status <= 10'd999), "status code above three digits")

    `HRSP_ASSERT(a_role_event, (m_valid && m_item.byte_role != hrsp_pkg::ROLE_SYNTAX) |-> (m_item.event_res == hrsp_pkg::EV_NONE || m_item.event_res == hrsp_pkg::EV_COMPLETE), "data byte carries a line event")

    `HRSP_ASSERT(a_name_fold, (m_valid && m_item.byte_role == hrsp_pkg::ROLE_NAME) |-> !((m_item.out_char >= "A" && m_item.out_char <= "Z") || m_item.out_char == "-"), "header name byte not folded")

endmodule

bind http_response_stream_parser hrsp_checker u_hrsp_checker (.*);

`default_nettype wire
